>>> rtl/core/dmisc_pkg.sv
// Package for the dual motor integral speed controller.
// Command, status and register index codes plus reset values of the registers.
// No dependencies.
package dmisc_pkg;

	localparam int unsigned SPEED_W = 16;
	localparam int unsigned DUTY_W  = 15;
	localparam int unsigned FREQ_W  = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic {
		CMD_SET  = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_RANGE = 2'd1,
		STATUS_MOTOR = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		MOTOR_NONE = 2'd0,
		MOTOR_ONE  = 2'd1,
		MOTOR_TWO  = 2'd2
	} motor_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_SPEED   = 3'd0,
		REG_GEAR_ONE_LIM = 3'd1,
		REG_GEAR_TWO_LIM = 3'd2,
		REG_GEAR_ONE_FRQ = 3'd3,
		REG_GEAR_TWO_FRQ = 3'd4,
		REG_GEAR_THR_FRQ = 3'd5
	} reg_idx_t;

	localparam logic [DUTY_W-1:0]         MAX_SPEED_RST      = 15'd300;
	localparam logic signed [SPEED_W-1:0] GEAR_ONE_LIMIT_RST = 16'sd100;
	localparam logic signed [SPEED_W-1:0] GEAR_TWO_LIMIT_RST = 16'sd200;
	localparam logic [FREQ_W-1:0]         GEAR_ONE_FREQ_RST  = 16'd1000;
	localparam logic [FREQ_W-1:0]         GEAR_TWO_FREQ_RST  = 16'd5000;
	localparam logic [FREQ_W-1:0]         GEAR_THR_FREQ_RST  = 16'd20000;

endpackage

>>> rtl/core/dmisc_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on dmisc_pkg.
interface dmisc_req_if import dmisc_pkg::*; ();
	logic                      valid;
	logic                      ready;
	cmd_t                      cmd;
	logic [1:0]                motor_sel;
	logic signed [SPEED_W-1:0] target_speed;
	logic signed [SPEED_W-1:0] measured_one;
	logic signed [SPEED_W-1:0] measured_two;

	modport source (output valid, cmd, motor_sel, target_speed, measured_one, measured_two,
		input ready);
	modport sink (input valid, cmd, motor_sel, target_speed, measured_one, measured_two,
		output ready);
endinterface

interface dmisc_rsp_if import dmisc_pkg::*; ();
	logic               valid;
	logic               ready;
	status_t            status;
	logic               freq_valid;
	logic [1:0]         freq_motor;
	logic [FREQ_W-1:0]  gear_freq;
	logic [DUTY_W-1:0]  duty_one;
	logic [DUTY_W-1:0]  duty_two;

	modport source (output valid, status, freq_valid, freq_motor, gear_freq, duty_one,
		duty_two, input ready);
	modport sink (input valid, status, freq_valid, freq_motor, gear_freq, duty_one,
		duty_two, output ready);
endinterface

>>> rtl/core/dmisc_integ.sv
// One integrator step: accumulator plus speed error, clamped to 0..max_speed.
// Depends on dmisc_pkg.
module dmisc_integ import dmisc_pkg::*; (
	input  logic [DUTY_W-1:0]         acc,
	input  logic signed [SPEED_W-1:0] setpoint,
	input  logic signed [SPEED_W-1:0] measured,
	input  logic [DUTY_W-1:0]         max_speed,
	output logic [DUTY_W-1:0]         acc_next
);

	logic signed [SPEED_W:0]   err;
	logic signed [SPEED_W+1:0] sum;

	// 18 bits hold the exact sum: never wraps
	assign err = {setpoint[SPEED_W-1], setpoint} - {measured[SPEED_W-1], measured};
	assign sum = signed'({3'b000, acc}) + {err[SPEED_W], err};

	always_comb begin
		if (sum[SPEED_W+1]) begin
			acc_next = '0;
		end else if (sum > signed'({3'b000, max_speed})) begin
			acc_next = max_speed;
		end else begin
			acc_next = sum[DUTY_W-1:0];
		end
	end

endmodule

>>> rtl/core/dual_motor_integral_speed_control.sv
// Dual motor integral speed controller: setpoint/gear selection and duty integration.
// Depends on dmisc_pkg, dmisc_if (dmisc_req_if, dmisc_rsp_if) and dmisc_integ.
//
// Usage:
//   req carries one command per transfer. cmd = CMD_SET stores target_speed as the
//   setpoint of motor_sel (1 or 2) after a range check against max_speed and reports
//   the PWM frequency code of the gear that the setpoint falls in. cmd = CMD_TICK
//   carries both measured speeds; each motor's duty accumulator takes the speed error
//   and is clamped to 0..max_speed.
//   rsp carries exactly one result per request: status, frequency report and both
//   duties as they stand after the command.
//   The result is registered and appears in the cycle after the request transfer. Throughput:
//   one request per cycle; the result register is refilled in the cycle it is taken.
//   When the receiver stalls, the result holds and req.ready drops until it is taken.
//   Reset: setpoints and accumulators clear to zero, registers return to their
//   defaults (max_speed 300, limits 100/200, frequencies 1000/5000/20000), rsp empty.
//   Configuration: cfg_we writes cfg_data to register cfg_index; unknown indexes are
//   ignored. Write only while no result is outstanding.
module dual_motor_integral_speed_control import dmisc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	dmisc_req_if.sink             req,
	dmisc_rsp_if.source           rsp
);

	logic [DUTY_W-1:0]         max_speed_q;
	logic signed [SPEED_W-1:0] gear_one_limit_q;
	logic signed [SPEED_W-1:0] gear_two_limit_q;
	logic [FREQ_W-1:0]         gear_one_freq_q;
	logic [FREQ_W-1:0]         gear_two_freq_q;
	logic [FREQ_W-1:0]         gear_three_freq_q;

	logic signed [SPEED_W-1:0] setpoint_one_q;
	logic signed [SPEED_W-1:0] setpoint_two_q;
	logic [DUTY_W-1:0]         accum_one_q;
	logic [DUTY_W-1:0]         accum_two_q;

	logic               rsp_valid_q;
	status_t            status_q;
	logic               freq_valid_q;
	logic [1:0]         freq_motor_q;
	logic [FREQ_W-1:0]  gear_freq_q;
	logic [DUTY_W-1:0]  duty_one_q;
	logic [DUTY_W-1:0]  duty_two_q;

	logic               req_xfer;
	logic               motor_ok;
	logic               range_ok;
	logic signed [SPEED_W:0] speed_ext;
	logic signed [SPEED_W:0] lim_ext;
	logic [DUTY_W-1:0]  integ_one;
	logic [DUTY_W-1:0]  integ_two;

	status_t            status_d;
	logic               freq_valid_d;
	logic [1:0]         freq_motor_d;
	logic [FREQ_W-1:0]  gear_freq_d;
	logic               set_one;
	logic               set_two;
	logic               tick;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign req_xfer  = req.valid && req.ready;

	dmisc_integ u_integ_one (
		.acc       (accum_one_q),
		.setpoint  (setpoint_one_q),
		.measured  (req.measured_one),
		.max_speed (max_speed_q),
		.acc_next  (integ_one)
	);

	dmisc_integ u_integ_two (
		.acc       (accum_two_q),
		.setpoint  (setpoint_two_q),
		.measured  (req.measured_two),
		.max_speed (max_speed_q),
		.acc_next  (integ_two)
	);

	assign speed_ext = {req.target_speed[SPEED_W-1], req.target_speed};
	assign lim_ext   = signed'({2'b00, max_speed_q});
	assign motor_ok  = (req.motor_sel == MOTOR_ONE) || (req.motor_sel == MOTOR_TWO);
	assign range_ok  = (speed_ext < lim_ext) && (speed_ext > -lim_ext);
	assign tick      = (req.cmd == CMD_TICK);

	always_comb begin
		status_d     = STATUS_OK;
		freq_valid_d = 1'b0;
		freq_motor_d = MOTOR_NONE;
		gear_freq_d  = '0;
		set_one      = 1'b0;
		set_two      = 1'b0;
		if (!tick) begin
			if (!motor_ok) begin
				status_d = STATUS_MOTOR;
			end else if (!range_ok) begin
				status_d = STATUS_RANGE;
			end else begin
				freq_valid_d = 1'b1;
				freq_motor_d = req.motor_sel;
				set_one      = (req.motor_sel == MOTOR_ONE);
				set_two      = (req.motor_sel == MOTOR_TWO);
				// upper limit checked first, even if the limits are out of order
				priority if (req.target_speed > gear_two_limit_q) begin
					gear_freq_d = gear_three_freq_q;
				end else if (req.target_speed > gear_one_limit_q) begin
					gear_freq_d = gear_two_freq_q;
				end else begin
					gear_freq_d = gear_one_freq_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q       <= MAX_SPEED_RST;
			gear_one_limit_q  <= GEAR_ONE_LIMIT_RST;
			gear_two_limit_q  <= GEAR_TWO_LIMIT_RST;
			gear_one_freq_q   <= GEAR_ONE_FREQ_RST;
			gear_two_freq_q   <= GEAR_TWO_FREQ_RST;
			gear_three_freq_q <= GEAR_THR_FREQ_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_SPEED:    max_speed_q       <= cfg_data[DUTY_W-1:0];
				REG_GEAR_ONE_LIM: gear_one_limit_q  <= signed'(cfg_data);
				REG_GEAR_TWO_LIM: gear_two_limit_q  <= signed'(cfg_data);
				REG_GEAR_ONE_FRQ: gear_one_freq_q   <= cfg_data;
				REG_GEAR_TWO_FRQ: gear_two_freq_q   <= cfg_data;
				REG_GEAR_THR_FRQ: gear_three_freq_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_one_q <= '0;
			setpoint_two_q <= '0;
			accum_one_q    <= '0;
			accum_two_q    <= '0;
		end else if (req_xfer) begin
			if (set_one) begin
				setpoint_one_q <= req.target_speed;
			end
			if (set_two) begin
				setpoint_two_q <= req.target_speed;
			end
			if (tick) begin
				accum_one_q <= integ_one;
				accum_two_q <= integ_two;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req.ready) begin
			rsp_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			status_q     <= status_d;
			freq_valid_q <= freq_valid_d;
			freq_motor_q <= freq_motor_d;
			gear_freq_q  <= gear_freq_d;
			duty_one_q   <= tick ? integ_one : accum_one_q;
			duty_two_q   <= tick ? integ_two : accum_two_q;
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.freq_valid = freq_valid_q;
	assign rsp.freq_motor = freq_motor_q;
	assign rsp.gear_freq  = gear_freq_q;
	assign rsp.duty_one   = duty_one_q;
	assign rsp.duty_two   = duty_two_q;

	a_stall_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !req.ready)
		else $error("request taken while result stalled");

	a_xfer_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> rsp.valid)
		else $error("request transfer without result");

	a_freq_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.freq_valid) |->
		(rsp.status == STATUS_OK && (rsp.freq_motor == MOTOR_ONE ||
		rsp.freq_motor == MOTOR_TWO)))
		else $error("frequency reported with bad status or motor");

	a_fail_no_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != STATUS_OK) |->
		(!rsp.freq_valid && rsp.gear_freq == '0 && rsp.freq_motor == MOTOR_NONE))
		else $error("frequency fields set on failed setpoint");

endmodule
